// ===== src/vlpd_pkg.sv =====
// Shared types and constants for the varint length-prefixed deframer.
package vlpd_pkg;

   localparam int VALUE_W              = 32;
   localparam int MAX_VARINT_BYTES_DEF = 5;
   localparam int QUEUE_DEPTH          = 4;
   localparam int QP_W                 = $clog2(QUEUE_DEPTH);
   localparam int QC_W                 = $clog2(QUEUE_DEPTH + 1);
   localparam int RSP_FIELDS_W         = 3 * VALUE_W + 8 + 2 + 1;
   localparam int RSP_DATA_W           = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_TOO_LONG = 2'd1;
   localparam logic [1:0] ERR_EARLY    = 2'd2;

   typedef enum logic [4:0] {
      PH_LEN  = 5'b00001,
      PH_ID   = 5'b00010,
      PH_TLEN = 5'b00100,
      PH_TEXT = 5'b01000,
      PH_SKIP = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [VALUE_W-1:0] frame_length;
      logic [VALUE_W-1:0] frame_id;
      logic [VALUE_W-1:0] text_length;
      logic [7:0]         text_byte;
      logic               text_last;
      logic [1:0]         error_code;
      logic               run_last;
   } res_type;

   typedef struct packed {
      logic [1:0] count;
      res_type    first;
      res_type    second;
   } res_bundle_type;

endpackage

// ===== src/vlpd_core.sv =====
// Varint header decoder and payload pass-through state for one byte per transfer.
module vlpd_core #(
   parameter int MAX_VARINT_BYTES = vlpd_pkg::MAX_VARINT_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  logic [7:0]               data_byte,
   input  logic                     segment_end,
   output vlpd_pkg::res_bundle_type results
);
   import vlpd_pkg::*;

   localparam int CNT_W = $clog2(MAX_VARINT_BYTES + 1);
   localparam int SH_W  = 7 * MAX_VARINT_BYTES + VALUE_W;
   localparam int SHA_W = $clog2(SH_W);

   phase_type          phase_ff, phase_in;
   logic [VALUE_W-1:0] accum_ff, accum_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [VALUE_W-1:0] len_ff, len_in;
   logic [VALUE_W-1:0] id_ff, id_in;
   logic [VALUE_W-1:0] remain_ff, remain_in;

   logic [SH_W-1:0]    chunk_ext;
   logic [SHA_W-1:0]   shamt;
   logic [VALUE_W-1:0] acc_new;
   logic [CNT_W-1:0]   cnt_new;
   logic               too_long;
   logic               early;
   logic               r0_vld;
   logic               last_byte;
   res_type            r0;
   res_type            err_rec;

   always_comb begin
      chunk_ext = {{(SH_W - 7){1'b0}}, data_byte[6:0]};
      shamt     = SHA_W'(7 * cnt_ff);
      acc_new   = accum_ff | VALUE_W'(chunk_ext << shamt);
      cnt_new   = cnt_ff + CNT_W'(1);
      too_long  = data_byte[7] && (cnt_new >= CNT_W'(MAX_VARINT_BYTES));
      last_byte = remain_ff <= VALUE_W'(1);

      phase_in  = phase_ff;
      accum_in  = accum_ff;
      cnt_in    = cnt_ff;
      len_in    = len_ff;
      id_in     = id_ff;
      remain_in = remain_ff;
      early     = 1'b0;
      r0_vld    = 1'b0;
      r0        = '0;

      unique case (phase_ff)
         PH_LEN, PH_ID, PH_TLEN: begin
            accum_in = acc_new;
            cnt_in   = cnt_new;
            if (too_long) begin
               r0_vld        = 1'b1;
               r0.kind       = KIND_ERROR;
               r0.error_code = ERR_TOO_LONG;
               phase_in      = PH_SKIP;
            end else if (data_byte[7]) begin
               early = 1'b1;
            end else begin
               accum_in = '0;
               cnt_in   = '0;
               if (phase_ff == PH_LEN) begin
                  len_in   = acc_new;
                  phase_in = PH_ID;
                  early    = 1'b1;
               end else if (phase_ff == PH_ID) begin
                  id_in = acc_new;
                  if (acc_new == '0) begin
                     phase_in = PH_TLEN;
                     early    = 1'b1;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end else begin
                  r0_vld          = 1'b1;
                  r0.kind         = KIND_HEADER;
                  r0.frame_length = len_ff;
                  r0.frame_id     = id_ff;
                  r0.text_length  = acc_new;
                  remain_in       = acc_new;
                  if (acc_new == '0) begin
                     phase_in = PH_SKIP;
                  end else begin
                     phase_in = PH_TEXT;
                     early    = 1'b1;
                  end
               end
            end
         end
         PH_TEXT: begin
            r0_vld       = 1'b1;
            r0.kind      = KIND_PAYLOAD;
            r0.text_byte = data_byte;
            r0.text_last = last_byte;
            remain_in    = last_byte ? '0 : remain_ff - VALUE_W'(1);
            if (last_byte) begin
               phase_in = PH_SKIP;
            end else begin
               early = 1'b1;
            end
         end
         PH_SKIP: begin
         end
         default: begin
            phase_in = PH_SKIP;
         end
      endcase

      if (segment_end) begin
         phase_in  = PH_LEN;
         accum_in  = '0;
         cnt_in    = '0;
         len_in    = '0;
         id_in     = '0;
         remain_in = '0;
      end

      err_rec            = '0;
      err_rec.kind       = KIND_ERROR;
      err_rec.error_code = ERR_EARLY;
      err_rec.run_last   = 1'b1;

      results = '0;
      if (r0_vld) begin
         results.first          = r0;
         results.first.run_last = !(segment_end && early);
         results.second         = err_rec;
         results.count          = (segment_end && early) ? 2'd2 : 2'd1;
      end else begin
         results.first = err_rec;
         results.count = (segment_end && early) ? 2'd1 : 2'd0;
      end
      if (!take) begin
         results.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEN;
         accum_ff  <= '0;
         cnt_ff    <= '0;
         len_ff    <= '0;
         id_ff     <= '0;
         remain_ff <= '0;
      end else if (take) begin
         phase_ff  <= phase_in;
         accum_ff  <= accum_in;
         cnt_ff    <= cnt_in;
         len_ff    <= len_in;
         id_ff     <= id_in;
         remain_ff <= remain_in;
      end
   end

endmodule

// ===== src/varint_length_prefixed_deframer_top.sv =====
// Top level of the varint length-prefixed deframer: decoder plus result queue.
//
//  channel | direction | payload
//  req_    | in        | tdata = data_byte, tlast = segment_end
//  rsp_    | out       | tdata = header/payload/error fields, tuser = kind, tlast = text_last
//
// One byte is taken per cycle while req_tready is high and it yields at most one result;
// a byte that yields a result plus an early-end error pushes two queue entries. The
// four-entry result queue sets the pace: req_tready is high while at least two are free.
// Reset is synchronous and returns the decoder to reading a length varint.
// A stall on rsp_ fills the queue and then drops req_tready.
module varint_length_prefixed_deframer_top #(
   parameter int MAX_VARINT_BYTES = vlpd_pkg::MAX_VARINT_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // data_byte
   input  logic                            req_tlast,  // segment_end
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // frame_length, frame_id, text_length, text_byte, error_code, run_last, zero pad
   output logic [vlpd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                      rsp_tuser,  // kind
   output logic                            rsp_tlast   // text_last
);
   import vlpd_pkg::*;

   res_bundle_type  bundle;
   res_type         q_ff [QUEUE_DEPTH];
   res_type         q_in [QUEUE_DEPTH];
   logic [QP_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0] cnt_ff, cnt_in;
   logic            req_take;
   logic            rsp_take;
   res_type         head;

   assign req_tready = cnt_ff <= QC_W'(QUEUE_DEPTH - 2);
   assign req_take   = req_tvalid && req_tready;

   vlpd_core #(
      .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .take       (req_take),
      .data_byte  (req_tdata),
      .segment_end(req_tlast),
      .results    (bundle)
   );

   assign head       = q_ff[rd_ptr_ff];
   assign rsp_tvalid = cnt_ff != '0;
   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.text_last;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, head.run_last, head.error_code,
                        head.text_byte, head.text_length, head.frame_id, head.frame_length};

   always_comb begin
      q_in = q_ff;
      if (bundle.count != 2'd0) begin
         q_in[wr_ptr_ff] = bundle.first;
      end
      if (bundle.count == 2'd2) begin
         q_in[wr_ptr_ff + QP_W'(1)] = bundle.second;
      end
      wr_ptr_in = wr_ptr_ff + QP_W'(bundle.count);
      rd_ptr_in = rd_ptr_ff + QP_W'(rsp_take);
      cnt_in    = cnt_ff + QC_W'(bundle.count) - QC_W'(rsp_take);
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QC_W'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_push_only_on_take: assert property (@(posedge clock) disable iff (reset)
      !req_take |-> bundle.count == 2'd0)
      else $error("results pushed without an input transfer");

   a_error_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_ERROR) |-> head.run_last)
      else $error("error record not last of its run");

   a_queue_empty_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
